>>> src/pskf_pkg.sv
// Shared constants and types for the per-axis scalar Kalman filter.
package pskf_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam int CFG_W    = 31;
  localparam int PADDR_W  = 3;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  localparam logic [31:0]      ONE_Q30           = 32'h4000_0000;
  localparam logic [CFG_W-1:0] PROCESS_NOISE_RST = 31'd1073742;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST    = 31'd107374182;

  typedef enum logic {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } reg_idx_t;

  // Work handed to the arithmetic engine for one update.
  typedef struct packed {
    logic signed [31:0] est;
    logic [31:0]        cov;
    logic [32:0]        den;
    logic signed [15:0] sample;
  } pskf_job_t;

  // Updated filter state returned by the engine.
  typedef struct packed {
    logic signed [31:0] est;
    logic [31:0]        cov;
  } pskf_upd_t;

endpackage

>>> src/per_axis_scalar_kalman_filter.sv
// Top level of the per-axis scalar Kalman filter with its register port.
//
//  Channel  Signals                                   Direction  Payload
//  config   psel penable pwrite paddr pwdata prdata   in/out     noise registers
//  input    in_valid in_ready                         in         axis, sample
//  output   out_valid out_ready                       out        axis_out, estimate
//
// An update runs the 31-step restoring division of the gain, followed by two multiplies
// on one 17x34 multiplier, two partial products each; the next input is taken once the
// result has moved into the output register. A zero gain denominator skips the division;
// an out-of-range axis answers with zero and no update. Synchronous reset restores the
// noise registers and all axis states at once. Input is held off while an update runs
// or its result waits for the output register to be free.
module per_axis_scalar_kalman_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pskf_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pskf_pkg::AXIS_W-1:0]       axis,
  input  logic signed [15:0]                sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pskf_pkg::AXIS_W-1:0]       axis_out,
  output logic signed [15:0]                estimate
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_PREP,
    T_RUN,
    T_OUT
  } tstate_t;

  tstate_t                        state;
  logic [pskf_pkg::CFG_W-1:0]     process_noise;
  logic [pskf_pkg::CFG_W-1:0]     measurement_noise;
  logic signed [31:0]             axis_estimate [pskf_pkg::NUM_AXES];
  logic [31:0]                    axis_covariance [pskf_pkg::NUM_AXES];
  logic [pskf_pkg::AXIS_W-1:0]    ax_q;
  logic signed [15:0]             sample_q;
  logic [31:0]                    run_p;
  logic [15:0]                    est_res;

  logic                           cfg_wr;
  logic [32:0]                    p_sum;
  logic [31:0]                    p_pred;
  logic [32:0]                    den;
  pskf_pkg::pskf_job_t            job;
  logic                           eng_start;
  logic                           eng_done;
  pskf_pkg::pskf_upd_t            eng_upd;
  logic [31:0]                    mag;
  logic [15:0]                    mag_int;
  logic [15:0]                    trunc_est;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = (state == T_IDLE);

  always_comb begin
    case (pskf_pkg::reg_idx_t'(paddr[2]))
      pskf_pkg::REG_PROCESS_NOISE:     prdata = {1'b0, process_noise};
      pskf_pkg::REG_MEASUREMENT_NOISE: prdata = {1'b0, measurement_noise};
      default:                         prdata = '0;
    endcase
  end

  // Prediction: covariance plus process noise, saturated to 32 bits.
  assign p_sum  = {1'b0, axis_covariance[ax_q]} + {2'b00, process_noise};
  assign p_pred = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
  assign den    = {1'b0, p_pred} + {2'b00, measurement_noise};

  assign job.est    = axis_estimate[ax_q];
  assign job.cov    = p_pred;
  assign job.den    = den;
  assign job.sample = sample_q;
  assign eng_start  = (state == T_PREP);

  pskf_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (eng_start),
    .job   (job),
    .done  (eng_done),
    .upd   (eng_upd)
  );

  // Truncate the Q15.16 estimate toward zero.
  assign mag       = eng_upd.est[31] ? (32'd0 - eng_upd.est) : eng_upd.est;
  assign mag_int   = mag[31:16];
  assign trunc_est = eng_upd.est[31] ? (16'd0 - mag_int) : mag_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= T_IDLE;
      out_valid         <= 1'b0;
      process_noise     <= pskf_pkg::PROCESS_NOISE_RST;
      measurement_noise <= pskf_pkg::MEAS_NOISE_RST;
      for (int i = 0; i < pskf_pkg::NUM_AXES; i++) begin
        axis_estimate[i]   <= '0;
        axis_covariance[i] <= pskf_pkg::ONE_Q30;
      end
    end else begin
      if (cfg_wr) begin
        case (pskf_pkg::reg_idx_t'(paddr[2]))
          pskf_pkg::REG_PROCESS_NOISE:     process_noise     <= pwdata[30:0];
          pskf_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= pwdata[30:0];
          default: ;
        endcase
      end

      // In T_OUT the output register is handled by the state machine below.
      if (out_valid && out_ready && state != T_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        T_IDLE: begin
          if (in_valid) begin
            ax_q     <= axis;
            sample_q <= sample;
            if (axis > pskf_pkg::AXIS_LAST) begin
              est_res <= '0;
              state   <= T_OUT;
            end else begin
              state <= T_PREP;
            end
          end
        end
        T_PREP: begin
          run_p <= p_pred;
          state <= T_RUN;
        end
        T_RUN: begin
          if (eng_done) begin
            axis_estimate[ax_q]   <= eng_upd.est;
            axis_covariance[ax_q] <= eng_upd.cov;
            est_res               <= trunc_est;
            state                 <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            axis_out  <= ax_q;
            estimate  <= est_res;
            state     <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> state == T_RUN)
    else $error("engine finished outside of an update");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> eng_upd.cov <= run_p)
    else $error("updated covariance exceeds predicted covariance");

  a_bad_axis: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && axis > pskf_pkg::AXIS_LAST) |=> (state == T_OUT && est_res == '0))
    else $error("out-of-range axis not answered with zero");

endmodule

>>> src/pskf_engine.sv
// Iterative gain division and shared multiplier for one filter update.
module pskf_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pskf_pkg::pskf_job_t   job,
  output logic                  done,
  output pskf_pkg::pskf_upd_t   upd
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_DIV,
    E_MUL_LO,
    E_MUL_HI,
    E_MUL_ACC,
    E_FIN
  } estate_t;

  estate_t              state;
  logic                 pass;
  logic [4:0]           cnt;
  logic [32:0]          rem;
  logic [30:0]          k;
  pskf_pkg::pskf_job_t  jb;
  logic signed [50:0]   prod;
  logic signed [63:0]   acc;
  logic signed [31:0]   x_new;

  logic                 bit_in;
  logic [33:0]          shifted;
  logic [33:0]          trial;
  logic                 geq;
  logic signed [33:0]   diff;
  logic signed [33:0]   op_a;
  logic [30:0]          op_m;
  logic [16:0]          chunk;
  logic signed [50:0]   mul;
  logic signed [63:0]   prod_ext;
  logic signed [63:0]   acc_sum;
  logic signed [63:0]   delta;

  // The dividend is P * 2^30; only P[0] is shifted in after the initial P >> 1.
  assign bit_in  = (cnt == 5'd30) ? jb.cov[0] : 1'b0;
  assign shifted = {rem, bit_in};
  assign geq     = shifted >= {1'b0, jb.den};
  assign trial   = shifted - {1'b0, jb.den};

  assign diff  = $signed({{2{jb.sample[15]}}, jb.sample, 16'h0000})
               - $signed({{2{jb.est[31]}}, jb.est});
  assign op_a  = pass ? $signed({2'b00, jb.cov}) : diff;
  assign op_m  = pass ? (pskf_pkg::ONE_Q30[30:0] - k) : k;
  assign chunk = (state == E_MUL_LO) ? {1'b0, op_m[15:0]} : {2'b00, op_m[30:16]};
  assign mul   = op_a * $signed(chunk);

  assign prod_ext = {{13{prod[50]}}, prod};
  assign acc_sum  = acc + {prod_ext[47:0], 16'h0000};
  // Arithmetic shift gives the floor toward minus infinity.
  assign delta    = acc >>> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
      pass  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= (state == E_FIN) && pass;
      case (state)
        E_IDLE: begin
          if (start) begin
            jb    <= job;
            rem   <= {2'b00, job.cov[31:1]};
            k     <= '0;
            cnt   <= 5'd30;
            pass  <= 1'b0;
            // A zero denominator leaves the gain at zero.
            state <= (job.den == 33'd0) ? E_MUL_LO : E_DIV;
          end
        end
        E_DIV: begin
          if (geq) begin
            rem <= trial[32:0];
            k   <= {k[29:0], 1'b1};
          end else begin
            rem <= shifted[32:0];
            k   <= {k[29:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= E_MUL_LO;
          end
        end
        E_MUL_LO: begin
          prod  <= mul;
          state <= E_MUL_HI;
        end
        E_MUL_HI: begin
          prod  <= mul;
          acc   <= prod_ext;
          state <= E_MUL_ACC;
        end
        E_MUL_ACC: begin
          acc   <= acc_sum;
          state <= E_FIN;
        end
        E_FIN: begin
          if (!pass) begin
            x_new <= jb.est + delta[31:0];
            pass  <= 1'b1;
            state <= E_MUL_LO;
          end else begin
            upd.est <= x_new;
            upd.cov <= acc[61:30];
            state   <= E_IDLE;
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == E_IDLE)
    else $error("engine started while busy");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == E_MUL_LO && !pass) |-> k <= pskf_pkg::ONE_Q30[30:0])
    else $error("gain above one");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == E_DIV |-> rem < jb.den)
    else $error("division remainder not below divisor");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the per-axis scalar Kalman filter.
module tb;

  localparam int     CYCLE_LIMIT = 500_000;
  localparam int     DRAIN_WAIT  = 60;
  localparam longint COV_MAX     = 64'h0000_0000_FFFF_FFFF;
  localparam longint ONE_FIX     = 64'h0000_0000_4000_0000;
  localparam int     PRINT_CAP   = 40;

  typedef logic [pskf_pkg::AXIS_W-1:0]  axis_t;
  typedef logic [pskf_pkg::PADDR_W-1:0] paddr_t;

  typedef struct {
    axis_t              axis;
    logic signed [15:0] estimate;
  } filter_result_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  paddr_t               paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  axis_t                axis;
  logic signed [15:0]   sample;
  logic                 out_valid;
  logic                 out_ready;
  axis_t                axis_out;
  logic signed [15:0]   estimate;

  // Filter state and noise settings as the block should hold them.
  int                           axis_est [pskf_pkg::NUM_AXES];
  logic [31:0]                  axis_cov [pskf_pkg::NUM_AXES];
  logic [pskf_pkg::CFG_W-1:0]   proc_noise;
  logic [pskf_pkg::CFG_W-1:0]   meas_noise;

  filter_result_t       pending_results[$];
  int                   truth [pskf_pkg::NUM_AXES];

  int error_count;
  int cycle_count;
  int sample_count;
  int out_of_range_count;
  int result_count;
  int cfg_write_count;
  int send_idle_pct;
  int recv_stall_pct;

  per_axis_scalar_kalman_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .axis      (axis),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .axis_out  (axis_out),
    .estimate  (estimate)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  // One filter update: predicts covariance, forms the gain, moves the estimate and covariance.
  function automatic logic signed [15:0] kalman_update(input axis_t ax,
                                                        input logic signed [15:0] s);
    longint cov_pred;
    longint den;
    longint gain;
    longint x;
    longint diff;
    longint whole;
    if (ax >= pskf_pkg::NUM_AXES)
      return '0;
    cov_pred = longint'(axis_cov[ax]) + longint'(proc_noise);
    if (cov_pred > COV_MAX)
      cov_pred = COV_MAX;
    den = cov_pred + longint'(meas_noise);
    gain = (den == 0) ? 0 : (cov_pred <<< 30) / den;
    x = longint'(axis_est[ax]);
    diff = longint'(s) * 65536 - x;
    x = x + ((gain * diff) >>> 30);
    axis_est[ax] = int'(x);
    axis_cov[ax] = 32'(((ONE_FIX - gain) * cov_pred) >>> 30);
    x = longint'(axis_est[ax]);
    whole = (x >= 0) ? (x >>> 16) : -((-x) >>> 16);
    return 16'(whole);
  endfunction

  // Result checker: every output transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result axis %0d estimate %0d",
                                  axis_out, estimate));
      end else begin
        want = pending_results.pop_front();
        if (axis_out !== want.axis)
          report_mismatch($sformatf("axis_out %0d, expected %0d", axis_out, want.axis));
        if (estimate !== want.estimate)
          report_mismatch($sformatf("estimate %0d on axis %0d, expected %0d",
                                    estimate, want.axis, want.estimate));
      end
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input axis_t ax, input logic signed [15:0] s);
    filter_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    axis     = ax;
    sample   = s;
    do @(posedge clk); while (!in_ready);
    want.axis     = ax;
    want.estimate = kalman_update(ax, s);
    pending_results.push_back(want);
    sample_count++;
    if (ax >= pskf_pkg::NUM_AXES)
      out_of_range_count++;
    @(negedge clk);
  endtask

  // Holds input off until every predicted result has been seen.
  task automatic wait_idle();
    in_valid = 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic cfg_write(input pskf_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = paddr_t'(4 * int'(idx));
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == pskf_pkg::REG_PROCESS_NOISE)
      proc_noise = value[pskf_pkg::CFG_W-1:0];
    else
      meas_noise = value[pskf_pkg::CFG_W-1:0];
    cfg_write_count++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic cfg_check(input pskf_pkg::reg_idx_t idx);
    logic [31:0] want;
    want    = (idx == pskf_pkg::REG_PROCESS_NOISE) ? {1'b0, proc_noise} : {1'b0, meas_noise};
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = paddr_t'(4 * int'(idx));
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register %s reads %h, expected %h", idx.name(),
                                prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(6))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h4000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom();
      5:       return $urandom_range(32'h0010_0000);
      default: return $urandom_range(32'h4000_0000);
    endcase
  endfunction

  task automatic reconfigure_random();
    cfg_write(pskf_pkg::REG_PROCESS_NOISE, pick_noise());
    cfg_write(pskf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
    cfg_check(pskf_pkg::REG_PROCESS_NOISE);
    cfg_check(pskf_pkg::REG_MEASUREMENT_NOISE);
  endtask

  task automatic test_reset_defaults();
    cfg_check(pskf_pkg::REG_PROCESS_NOISE);
    cfg_check(pskf_pkg::REG_MEASUREMENT_NOISE);
    send_sample(2'd0, 16'sd32767);
    send_sample(2'd1, -16'sd32768);
    send_sample(2'd2, 16'sd0);
    send_sample(2'd3, -16'sd1);
    send_sample(2'd0, -16'sd32768);
    send_sample(2'd1, 16'sd32767);
    send_sample(2'd2, 16'sd1);
    send_sample(2'd0, 16'sd32767);
    wait_idle();
  endtask

  // Bit 31 of the write data is not part of either register.
  task automatic test_register_access();
    cfg_write(pskf_pkg::REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    cfg_check(pskf_pkg::REG_PROCESS_NOISE);
    cfg_write(pskf_pkg::REG_MEASUREMENT_NOISE, 32'h8000_0000);
    cfg_check(pskf_pkg::REG_MEASUREMENT_NOISE);
    cfg_write(pskf_pkg::REG_PROCESS_NOISE, 32'h0000_0000);
    cfg_check(pskf_pkg::REG_PROCESS_NOISE);
    cfg_write(pskf_pkg::REG_MEASUREMENT_NOISE, 32'h5555_5555);
    cfg_check(pskf_pkg::REG_MEASUREMENT_NOISE);
  endtask

  // With no measurement noise the gain is exactly one and the estimate jumps to the sample.
  task automatic test_unity_gain();
    cfg_write(pskf_pkg::REG_PROCESS_NOISE, 32'h4000_0000);
    cfg_write(pskf_pkg::REG_MEASUREMENT_NOISE, 32'h0000_0000);
    send_sample(2'd0, -16'sd32768);
    send_sample(2'd1, 16'sd32767);
    send_sample(2'd2, -16'sd12345);
    send_sample(2'd3, 16'sd32767);
    wait_idle();
  endtask

  // Covariance is now zero, so with both noises zero the denominator vanishes.
  task automatic test_zero_denominator();
    cfg_write(pskf_pkg::REG_PROCESS_NOISE, 32'h0000_0000);
    send_sample(2'd0, 16'sd32767);
    send_sample(2'd1, -16'sd32768);
    send_sample(2'd2, 16'sd0);
    wait_idle();
  endtask

  task automatic test_noise_extremes();
    cfg_write(pskf_pkg::REG_PROCESS_NOISE, 32'h7FFF_FFFF);
    cfg_write(pskf_pkg::REG_MEASUREMENT_NOISE, 32'h7FFF_FFFF);
    send_sample(2'd0, 16'sd32767);
    send_sample(2'd0, 16'sd32767);
    send_sample(2'd1, -16'sd32768);
    wait_idle();
    cfg_write(pskf_pkg::REG_PROCESS_NOISE, 32'h0000_0000);
    cfg_write(pskf_pkg::REG_MEASUREMENT_NOISE, 32'h0000_0001);
    send_sample(2'd2, -16'sd32768);
    send_sample(2'd1, 16'sd32767);
    wait_idle();
  endtask

  function automatic logic signed [15:0] next_sample(input axis_t ax);
    int v;
    if (ax >= pskf_pkg::NUM_AXES)
      return 16'($urandom());
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom());
      3:       return ($urandom_range(1) != 0) ? 16'sd32767 : -16'sd32768;
      default: begin
        // Tracking a slowly moving true value gives the filter realistic work.
        truth[ax] = truth[ax] + int'($urandom_range(200)) - 100;
        if (truth[ax] > 32767)
          truth[ax] = 32767;
        if (truth[ax] < -32768)
          truth[ax] = -32768;
        v = truth[ax] + int'($urandom_range(64)) - 32;
        if (v > 32767)
          v = 32767;
        if (v < -32768)
          v = -32768;
        return 16'(v);
      end
    endcase
  endfunction

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count);
    axis_t ax;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    reconfigure_random();
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_idle();
        reconfigure_random();
      end else if ($urandom_range(63) == 0) begin
        wait_idle();
      end
      ax = ($urandom_range(99) < 8) ? axis_t'(pskf_pkg::NUM_AXES)
                                    : axis_t'($urandom_range(pskf_pkg::NUM_AXES - 1));
      send_sample(ax, next_sample(ax));
    end
    wait_idle();
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    axis           = '0;
    sample         = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    proc_noise     = pskf_pkg::PROCESS_NOISE_RST;
    meas_noise     = pskf_pkg::MEAS_NOISE_RST;
    for (int i = 0; i < pskf_pkg::NUM_AXES; i++) begin
      axis_est[i] = 0;
      axis_cov[i] = pskf_pkg::ONE_Q30;
      truth[i]    = int'($urandom_range(40000)) - 20000;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_register_access();
    test_unity_gain();
    test_zero_denominator();
    test_noise_extremes();
    test_random_traffic(0, 0, 160);
    test_random_traffic(86, 0, 160);
    test_random_traffic(0, 86, 160);
    test_random_traffic(14, 14, 160);

    in_valid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d samples (%0d on an out-of-range axis), checked %0d results,",
             sample_count, out_of_range_count, result_count);
    $display("with %0d register writes over four pacing phases.", cfg_write_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
